[src/insertion_ordered_key_table_macros.svh]
// Assertion macros shared by the key table RTL.
`ifndef INSERTION_ORDERED_KEY_TABLE_MACROS_SVH
`define INSERTION_ORDERED_KEY_TABLE_MACROS_SVH

// Condition holds in the same cycle as the trigger.
`define IOKT_ASSERT_SAME(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error("key table check failed");

// Condition holds in the cycle after the trigger.
`define IOKT_ASSERT_NEXT(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error("key table check failed");

`endif

[src/iokt_pkg.sv]
// Shared types and codes for the insertion-ordered key table.
`timescale 1ns / 1ps
package iokt_pkg;

   typedef enum logic [2:0] {
      OP_INSERT = 3'd0,
      OP_FIND   = 3'd1,
      OP_ERASE  = 3'd2,
      OP_LIST   = 3'd3,
      OP_REMOVE = 3'd4
   } opcode_type;

   localparam logic [1:0] ST_ENTRY = 2'd0;
   localparam logic [1:0] ST_END   = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   localparam logic [4:0] RUN_MAX = 5'd16;

   // Write enables that the sequencer hands to one slot cell.
   typedef struct packed {
      logic entry;
      logic value;
      logic next;
      logic prev;
      logic clear;
   } cell_we_type;

endpackage

[src/iokt_cell.sv]
// One slot of the key table: key, value, links, valid mark and key compare.
`timescale 1ns / 1ps
module iokt_cell #(
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32,
   parameter int IW         = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  iokt_pkg::cell_we_type   we,
   input  logic [KEY_BITS-1:0]     wr_key,
   input  logic [VALUE_BITS-1:0]   wr_value,
   input  logic [IW-1:0]           wr_next,
   input  logic [IW-1:0]           wr_prev,
   input  logic [KEY_BITS-1:0]     cmp_key,
   input  logic                    free_seen_in,
   output logic                    free_seen_out,
   output logic                    first_free,
   output logic                    match,
   output logic                    valid,
   output logic [KEY_BITS-1:0]     key,
   output logic [VALUE_BITS-1:0]   value,
   output logic [IW-1:0]           next,
   output logic [IW-1:0]           prev
);

   logic                  valid_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic [IW-1:0]         next_ff;
   logic [IW-1:0]         prev_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (we.entry) begin
         valid_ff <= 1'b1;
      end else if (we.clear) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (we.entry) begin
         key_ff <= wr_key;
      end
      if (we.entry || we.value) begin
         value_ff <= wr_value;
      end
      if (we.entry) begin
         next_ff <= '0;
      end else if (we.next) begin
         next_ff <= wr_next;
      end
      if (we.entry || we.prev) begin
         prev_ff <= wr_prev;
      end
   end

   // The free mark ripples along the row so only the lowest free slot claims.
   assign first_free    = !valid_ff && !free_seen_in;
   assign free_seen_out = free_seen_in || !valid_ff;
   assign match         = valid_ff && (key_ff == cmp_key);
   assign valid         = valid_ff;
   assign key           = key_ff;
   assign value         = value_ff;
   assign next          = next_ff;
   assign prev          = prev_ff;

endmodule

[src/insertion_ordered_key_table.sv]
// Top level of the insertion-ordered key table: slot row and sequencer.
//
// Usage: items enter on the req_ channel (opcode, key, value, count) with a
// valid/ready handshake; results leave on the rsp_ channel, one or more per
// item, the final one flagged by rsp_last. Every slot is a cell of a row
// that compares the key in parallel and keeps its doubly linked neighbors.
// Steps: insert, find, unknown opcodes and misses are looked up in S_LOOK,
// which writes a registered result; erase with a follower and remove-run
// with zero count go on to S_CUR for their result. A list run gives its
// results from S_LIST, one per cycle while the receiver takes them; a
// remove run walks one entry per cycle in S_REM while the output register
// is free; it gives its result at the end, earlier if it reaches the tail.
// A run holds the input while it walks its entries.
// The next item is accepted as soon as the sequencer has returned to idle,
// even while the last result waits.
// When the receiver stalls, the sequencer holds in place until the output
// register frees. Reset clears the valid marks, head, tail and fill count;
// the table is usable in the first cycle after reset.
`timescale 1ns / 1ps
module insertion_ordered_key_table #(
   parameter int CAPACITY   = 16,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_opcode,
   input  logic signed [31:0] req_key,
   input  logic signed [31:0] req_value,
   input  logic [4:0]         req_count,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_entry_key,
   output logic signed [31:0] rsp_entry_value,
   output logic               rsp_last
);
   `include "insertion_ordered_key_table_macros.svh"

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int UW = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {S_IDLE, S_LOOK, S_CUR, S_LIST, S_REM} state_type;

   state_type             state_ff, state_in;
   logic [2:0]            op_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] val_ff;
   logic [4:0]            cnt_ff;
   logic [IW-1:0]         cur_ff, cur_in;
   logic [4:0]            left_ff, left_in;
   logic [IW-1:0]         head_ff, head_in;
   logic [IW-1:0]         tail_ff, tail_in;
   logic [UW-1:0]         used_ff, used_in;

   logic                  rsp_valid_ff;
   logic [1:0]            rsp_status_ff;
   logic [31:0]           rsp_key_ff;
   logic [31:0]           rsp_value_ff;
   logic                  rsp_last_ff;

   logic                  emit;
   logic [1:0]            e_status;
   logic [31:0]           e_key;
   logic [31:0]           e_value;
   logic                  e_last;

   iokt_pkg::cell_we_type we [CAPACITY];
   logic [KEY_BITS-1:0]   ck [CAPACITY];
   logic [VALUE_BITS-1:0] cv [CAPACITY];
   logic [IW-1:0]         cn [CAPACITY];
   logic [IW-1:0]         cp [CAPACITY];
   logic [CAPACITY-1:0]   match_vec, valid_vec, ffree_vec, fseen_vec;

   logic                  en_entry, en_value, en_next, en_prev, en_clear;
   logic [IW-1:0]         ix_entry, ix_value, ix_next, ix_prev, ix_clear;
   logic [IW-1:0]         wr_next_d, wr_prev_d;
   logic [VALUE_BITS-1:0] wr_value_d;

   logic                  found, any_free, out_free, do_unlink, un_has;
   logic [IW-1:0]         match_idx, free_idx, rd_idx;
   logic [KEY_BITS-1:0]   rd_key;
   logic [VALUE_BITS-1:0] rd_value;
   logic [IW-1:0]         rd_next, rd_prev;
   logic [UW-1:0]         used_dec;
   logic                  list_end;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      always_comb begin
         we[g].entry = en_entry && (ix_entry == IW'(g));
         we[g].value = en_value && (ix_value == IW'(g));
         we[g].next  = en_next  && (ix_next  == IW'(g));
         we[g].prev  = en_prev  && (ix_prev  == IW'(g));
         we[g].clear = en_clear && (ix_clear == IW'(g));
      end
      iokt_cell #(
         .KEY_BITS   (KEY_BITS),
         .VALUE_BITS (VALUE_BITS),
         .IW         (IW)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .we            (we[g]),
         .wr_key        (key_ff),
         .wr_value      (wr_value_d),
         .wr_next       (wr_next_d),
         .wr_prev       (wr_prev_d),
         .cmp_key       (key_ff),
         .free_seen_in  ((g == 0) ? 1'b0 : fseen_vec[(g == 0) ? 0 : g - 1]),
         .free_seen_out (fseen_vec[g]),
         .first_free    (ffree_vec[g]),
         .match         (match_vec[g]),
         .valid         (valid_vec[g]),
         .key           (ck[g]),
         .value         (cv[g]),
         .next          (cn[g]),
         .prev          (cp[g])
      );
   end

   always_comb begin
      match_idx = '0;
      free_idx  = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (match_vec[i]) begin
            match_idx = match_idx | IW'(i);
         end
         if (ffree_vec[i]) begin
            free_idx = free_idx | IW'(i);
         end
      end
   end

   assign found    = |match_vec;
   assign any_free = fseen_vec[CAPACITY-1];
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign rd_idx   = (state_ff == S_LOOK) ? match_idx : cur_ff;
   assign rd_key   = ck[rd_idx];
   assign rd_value = cv[rd_idx];
   assign rd_next  = cn[rd_idx];
   assign rd_prev  = cp[rd_idx];
   assign un_has   = (rd_idx != tail_ff);
   assign used_dec = (used_ff != '0) ? used_ff - UW'(1) : used_ff;
   assign list_end = (left_ff == 5'd1) || (cur_ff == tail_ff);

   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      left_in    = left_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      used_in    = used_ff;
      emit       = 1'b0;
      e_status   = iokt_pkg::ST_END;
      e_key      = '0;
      e_value    = '0;
      e_last     = 1'b1;
      en_entry   = 1'b0;
      en_value   = 1'b0;
      en_next    = 1'b0;
      en_prev    = 1'b0;
      en_clear   = 1'b0;
      ix_entry   = free_idx;
      ix_value   = match_idx;
      ix_next    = '0;
      ix_prev    = '0;
      ix_clear   = rd_idx;
      wr_next_d  = '0;
      wr_prev_d  = '0;
      wr_value_d = val_ff;
      do_unlink  = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            if (out_free) begin
               state_in = S_IDLE;
               emit     = 1'b1;
               unique case (op_ff)
                  iokt_pkg::OP_INSERT: begin
                     if (found) begin
                        en_value = 1'b1;
                        e_status = iokt_pkg::ST_ENTRY;
                        e_key    = 32'(key_ff);
                        e_value  = 32'(val_ff);
                     end else if (!any_free) begin
                        e_status = iokt_pkg::ST_FULL;
                     end else begin
                        en_entry  = 1'b1;
                        wr_prev_d = (used_ff == '0) ? '0 : tail_ff;
                        if (used_ff != '0) begin
                           en_next   = 1'b1;
                           ix_next   = tail_ff;
                           wr_next_d = free_idx;
                        end else begin
                           head_in = free_idx;
                        end
                        tail_in  = free_idx;
                        used_in  = used_ff + UW'(1);
                        e_status = iokt_pkg::ST_ENTRY;
                        e_key    = 32'(key_ff);
                        e_value  = 32'(val_ff);
                     end
                  end
                  iokt_pkg::OP_FIND: begin
                     if (found) begin
                        e_status = iokt_pkg::ST_ENTRY;
                        e_key    = 32'(rd_key);
                        e_value  = 32'(rd_value);
                     end
                  end
                  iokt_pkg::OP_ERASE: begin
                     if (found) begin
                        do_unlink = 1'b1;
                        if (un_has) begin
                           emit     = 1'b0;
                           cur_in   = rd_next;
                           state_in = S_CUR;
                        end
                     end
                  end
                  iokt_pkg::OP_LIST: begin
                     if (found && (cnt_ff != '0)) begin
                        emit     = 1'b0;
                        cur_in   = match_idx;
                        left_in  = cnt_ff;
                        state_in = S_LIST;
                     end
                  end
                  iokt_pkg::OP_REMOVE: begin
                     if (found) begin
                        emit    = 1'b0;
                        cur_in  = match_idx;
                        left_in = cnt_ff;
                        state_in = (cnt_ff == '0) ? S_CUR : S_REM;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_CUR: begin
            if (out_free) begin
               emit     = 1'b1;
               e_status = iokt_pkg::ST_ENTRY;
               e_key    = 32'(rd_key);
               e_value  = 32'(rd_value);
               state_in = S_IDLE;
            end
         end
         S_LIST: begin
            if (out_free) begin
               emit     = 1'b1;
               e_status = iokt_pkg::ST_ENTRY;
               e_key    = 32'(rd_key);
               e_value  = 32'(rd_value);
               e_last   = list_end;
               if (list_end) begin
                  state_in = S_IDLE;
               end else begin
                  cur_in  = rd_next;
                  left_in = left_ff - 5'd1;
               end
            end
         end
         S_REM: begin
            if (out_free) begin
               do_unlink = 1'b1;
               left_in   = left_ff - 5'd1;
               cur_in    = rd_next;
               if (!un_has) begin
                  emit     = 1'b1;
                  state_in = S_IDLE;
               end else if (left_ff == 5'd1) begin
                  state_in = S_CUR;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Unlink the slot under rd_idx from the chain.
      if (do_unlink) begin
         en_clear = 1'b1;
         if (rd_idx == head_ff) begin
            if (un_has) begin
               head_in = rd_next;
            end
         end else begin
            en_next   = 1'b1;
            ix_next   = rd_prev;
            wr_next_d = rd_next;
         end
         if (un_has) begin
            en_prev   = 1'b1;
            ix_prev   = rd_next;
            wr_prev_d = rd_prev;
         end else begin
            tail_in = rd_prev;
         end
         used_in = used_dec;
         if (used_dec == '0) begin
            head_in = '0;
            tail_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         used_ff  <= used_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      left_ff <= left_in;
      if (req_valid && req_ready) begin
         op_ff  <= req_opcode;
         key_ff <= KEY_BITS'({{32{req_key[31]}}, req_key});
         val_ff <= VALUE_BITS'({{32{req_value[31]}}, req_value});
         cnt_ff <= (req_count > iokt_pkg::RUN_MAX) ? iokt_pkg::RUN_MAX : req_count;
      end
      if (emit) begin
         rsp_status_ff <= e_status;
         rsp_key_ff    <= e_key;
         rsp_value_ff  <= e_value;
         rsp_last_ff   <= e_last;
      end
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_key   = rsp_key_ff;
   assign rsp_entry_value = rsp_value_ff;
   assign rsp_last        = rsp_last_ff;

   `IOKT_ASSERT_SAME(a_fill_matches_marks, 1'b1, $countones(valid_vec) == used_ff)
   `IOKT_ASSERT_SAME(a_fill_bounded, 1'b1, used_ff <= UW'(CAPACITY))
   `IOKT_ASSERT_NEXT(a_accept_to_lookup, req_valid && req_ready, state_ff == S_LOOK)
   `IOKT_ASSERT_NEXT(a_stall_holds, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status))

endmodule
